>>> rtl/prch_pkg.sv
// ----------------------------------------------------------------------------
// prch_pkg
// Shared types and codes for the point hit-test unit: beat layouts, table
// entry layout, operation and figure codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package prch_pkg;

	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int PNUM_W   = 16;
	localparam int FIG_W    = 5;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	localparam logic KIND_RECT   = 1'b0;
	localparam logic KIND_CIRCLE = 1'b1;

	typedef struct packed {
		logic [1:0]                 operation;
		logic                       figure_kind;
		logic signed [COORD_W-1:0]  first_x;
		logic signed [COORD_W-1:0]  first_y;
		logic signed [COORD_W-1:0]  second_x;
		logic signed [COORD_W-1:0]  second_y;
		logic [RADIUS_W-1:0]        radius;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
	} in_beat_t;

	typedef struct packed {
		logic [PNUM_W-1:0] point_number;
		logic [FIG_W-1:0]  figure_number;
		logic              contained;
		logic              last_result;
	} out_beat_t;

	// one stored figure; circles keep the radius in right_or_radius
	typedef struct packed {
		logic                       kind;
		logic signed [COORD_W-1:0]  left_or_cx;
		logic signed [COORD_W-1:0]  top_or_cy;
		logic signed [COORD_W-1:0]  right_or_radius;
		logic signed [COORD_W-1:0]  bottom;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic clear;   // empty table, restart point numbering
		logic add;     // append figure from the input beat
		logic start;   // latch query point and its number
		logic issue;   // read one table entry into the compare pipe
		logic finish;  // emit the closing result of this point
	} cmd_t;

	typedef struct packed {
		logic adv;     // pipe and result register may move this cycle
		logic busy;    // compare pipe holds figures in flight
	} status_t;

endpackage

>>> rtl/prch_ctrl.sv
// ----------------------------------------------------------------------------
// prch_ctrl
// Sequencer: takes input beats; walks the figure table for a test point,
// one entry per cycle unless results stall, then empties the pipe and closes.
// ----------------------------------------------------------------------------
module prch_ctrl #(
	parameter int MAX_FIGURES = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       item_valid,
	input  logic [1:0]                                 item_op,
	output logic                                       item_ready,
	input  logic [$clog2(MAX_FIGURES+1)-1:0]           fig_count,
	input  prch_pkg::status_t                          status,
	output prch_pkg::cmd_t                             cmd,
	output logic [((MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1)-1:0] rd_addr
);
	import prch_pkg::*;

	localparam int CW = $clog2(MAX_FIGURES + 1);
	localparam int AW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;

	state_t        state_q, state_d;
	logic [CW-1:0] idx_q;
	logic          accept;
	logic          issue;
	logic          last_issue;

	assign accept     = item_valid && item_ready;
	assign issue      = (state_q == ST_SCAN) && (idx_q != fig_count) && status.adv;
	assign last_issue = issue && ((idx_q + CW'(1)) == fig_count);
	assign rd_addr    = idx_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item_op == OP_TEST) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fig_count == '0 || last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy && status.adv) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.clear  = accept && item_op == OP_CLEAR;
				cmd.add    = accept && item_op == OP_ADD;
				cmd.start  = accept && item_op == OP_TEST;
			end
			ST_SCAN: begin
				cmd.issue = issue;
			end
			ST_DRAIN: begin
				cmd.finish = !status.busy && status.adv;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

endmodule

>>> rtl/prch_dp.sv
// ----------------------------------------------------------------------------
// prch_dp
// Datapath: figure table memory, point counter, three-stage compare pipe
// (read, diff, square; then sum-and-compare), held-back hit, result register.
// ----------------------------------------------------------------------------
module prch_dp #(
	parameter int MAX_FIGURES = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  prch_pkg::in_beat_t                         item,
	input  prch_pkg::cmd_t                             cmd,
	input  logic [((MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1)-1:0] rd_addr,
	output prch_pkg::status_t                          status,
	output logic [$clog2(MAX_FIGURES+1)-1:0]           fig_count,
	output logic                                       result_valid,
	input  logic                                       result_ready,
	output prch_pkg::out_beat_t                        result
);
	import prch_pkg::*;

	localparam int CW = $clog2(MAX_FIGURES + 1);
	localparam int AW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
	localparam int DW = COORD_W + 1;      // coordinate difference
	localparam int SW = 2 * COORD_W + 1;  // square of a difference
	localparam int RW = 2 * RADIUS_W;     // square of a radius

	entry_t mem [MAX_FIGURES];

	logic [CW-1:0]             fig_count_q;
	logic [PNUM_W-1:0]         next_pnum_q;
	logic [PNUM_W-1:0]         pnum_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic                      adv;
	entry_t                    wr_entry;

	// stage 1: table read
	logic                      v_s1;
	entry_t                    rd_s1;
	logic [FIG_W-1:0]          num_s1;
	// stage 2: differences and rectangle test
	logic                      v_s2;
	logic                      kind_s2;
	logic                      rect_hit_s2;
	logic signed [DW-1:0]      dx_s2, dy_s2;
	logic [RADIUS_W-1:0]       r_s2;
	logic [FIG_W-1:0]          num_s2;
	// stage 3: squares
	logic                      v_s3;
	logic                      kind_s3;
	logic                      rect_hit_s3;
	logic [SW-1:0]             dxx_s3, dyy_s3;
	logic [RW-1:0]             rr_s3;
	logic [FIG_W-1:0]          num_s3;

	logic signed [2*DW-1:0]    dxx_full, dyy_full;
	logic [SW:0]               dist_sq;
	logic                      hit;
	logic                      pend_valid_q;
	logic [FIG_W-1:0]          pend_num_q;
	logic                      out_valid_q;
	out_beat_t                 out_q;
	logic                      load_hit;

	assign adv          = !out_valid_q || result_ready;
	assign status.adv   = adv;
	assign status.busy  = v_s1 || v_s2 || v_s3;
	assign fig_count    = fig_count_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		wr_entry            = '0;
		wr_entry.kind       = item.figure_kind;
		wr_entry.left_or_cx = item.first_x;
		wr_entry.top_or_cy  = item.first_y;
		if (item.figure_kind == KIND_RECT) begin
			wr_entry.right_or_radius = item.second_x;
			wr_entry.bottom          = item.second_y;
		end else begin
			wr_entry.right_or_radius = COORD_W'(item.radius);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && fig_count_q < CW'(MAX_FIGURES)) begin
			mem[fig_count_q[AW-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// table fill and point numbering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fig_count_q <= '0;
			next_pnum_q <= PNUM_W'(1);
		end else if (cmd.clear) begin
			fig_count_q <= '0;
			next_pnum_q <= PNUM_W'(1);
		end else if (cmd.add && fig_count_q < CW'(MAX_FIGURES)) begin
			fig_count_q <= fig_count_q + CW'(1);
		end else if (cmd.start) begin
			next_pnum_q <= (next_pnum_q == '1) ? PNUM_W'(1) : next_pnum_q + PNUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pnum_q <= next_pnum_q;
			px_q   <= item.point_x;
			py_q   <= item.point_y;
		end
	end

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign dxx_full = dx_s2 * dx_s2;
	assign dyy_full = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1      <= FIG_W'(rd_addr) + FIG_W'(1);

			kind_s2     <= rd_s1.kind;
			rect_hit_s2 <= (px_q > rd_s1.left_or_cx) && (px_q < rd_s1.right_or_radius) &&
			               (py_q < rd_s1.top_or_cy) && (py_q > rd_s1.bottom);
			dx_s2       <= {px_q[COORD_W-1], px_q} -
			               {rd_s1.left_or_cx[COORD_W-1], rd_s1.left_or_cx};
			dy_s2       <= {py_q[COORD_W-1], py_q} -
			               {rd_s1.top_or_cy[COORD_W-1], rd_s1.top_or_cy};
			r_s2        <= rd_s1.right_or_radius[RADIUS_W-1:0];
			num_s2      <= num_s1;

			kind_s3     <= kind_s2;
			rect_hit_s3 <= rect_hit_s2;
			dxx_s3      <= dxx_full[SW-1:0];
			dyy_s3      <= dyy_full[SW-1:0];
			rr_s3       <= r_s2 * r_s2;
			num_s3      <= num_s2;
		end
	end

	assign dist_sq  = {1'b0, dxx_s3} + {1'b0, dyy_s3};
	assign hit      = (kind_s3 == KIND_CIRCLE) ? (dist_sq < (SW+1)'(rr_s3)) : rect_hit_s3;
	assign load_hit = adv && v_s3 && hit && pend_valid_q;

	// a hit is held back until the next one shows it was not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end else if (adv && v_s3 && hit) begin
				pend_valid_q <= 1'b1;
			end
			if (load_hit || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && hit) begin
			pend_num_q <= num_s3;
		end
		if (cmd.finish) begin
			out_q.point_number  <= pnum_q;
			out_q.figure_number <= pend_valid_q ? pend_num_q : '0;
			out_q.contained     <= pend_valid_q;
			out_q.last_result   <= 1'b1;
		end else if (load_hit) begin
			out_q.point_number  <= pnum_q;
			out_q.figure_number <= pend_num_q;
			out_q.contained     <= 1'b1;
			out_q.last_result   <= 1'b0;
		end
	end

endmodule

>>> rtl/point_in_rect_circle_hit_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_rect_circle_hit_test_unit
// Figure table with point hit test: loads rectangles and circles, then
// reports every stored figure that strictly contains a query point.
// ----------------------------------------------------------------------------
//
//  channel  | signals                           | beat
//  ---------+-----------------------------------+------------------------------
//  item     | item_valid, item_ready, item      | clear, add figure, test point
//  result   | result_valid, result_ready, result| one hit, or not contained
//
//  While a test point is worked on, the input is held. The single read port
//  of the figure table delivers one entry per cycle, unless a result stalls,
//  into a three-stage compare pipe, which then drains before the closing beat
//  is written. Items are taken one at a time; item_ready is high only between
//  tests. Reset empties the table and sets the point number to 1. A stalled
//  result freezes the compare pipe in place.
//
module point_in_rect_circle_hit_test_unit #(
	parameter int MAX_FIGURES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  prch_pkg::in_beat_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output prch_pkg::out_beat_t result
);
	import prch_pkg::*;

	localparam int CW = $clog2(MAX_FIGURES + 1);
	localparam int AW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;

	cmd_t          cmd;
	status_t       status;
	logic [CW-1:0] fig_count;
	logic [AW-1:0] rd_addr;

	// sequencer: accepts beats and walks the table
	prch_ctrl #(
		.MAX_FIGURES(MAX_FIGURES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_op   (item.operation),
		.item_ready(item_ready),
		.fig_count (fig_count),
		.status    (status),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// table, compare pipe and result register
	prch_dp #(
		.MAX_FIGURES(MAX_FIGURES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.status      (status),
		.fig_count   (fig_count),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef NO_ASSERTIONS
	// no figures in flight while new beats are taken
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !status.busy)
		else $error("compare pipe busy while taking input");

	// a table read only when the pipe may move
	a_issue_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> status.adv)
		else $error("table read while pipe stalled");

	// closing beat of a point is marked last
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid && result.last_result)
		else $error("closing beat missing or not marked last");

	// a test point blocks further input
	a_test_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.operation == OP_TEST |=> !item_ready)
		else $error("input taken during a test");
`endif

endmodule

>>> verif/point_in_rect_circle_hit_test_unit_tb.sv
// ----------------------------------------------------------------------------
// point_in_rect_circle_hit_test_unit_tb
// Self-checking bench for the point hit-test unit. A scoreboard class keeps
// its own figure table and point counter. For every accepted item beat it
// works out the result beats that the unit must return, and it checks each
// returned beat field by field against the oldest one still owed. Stimulus is
// a directed opening and then random scenes: load figures and probe points
// aimed at them. Random noise items are mixed in.
// ----------------------------------------------------------------------------
package hit_test_tb_pkg;

	import prch_pkg::*;

	localparam int         TABLE_DEPTH = 16;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         MAX_REPORTS = 40;

	class hit_list_checker;
		entry_t            figures[TABLE_DEPTH];
		int unsigned       fig_count;
		logic [PNUM_W-1:0] next_point;
		out_beat_t         owed_hits[$];
		int                errors;

		function new();
			fig_count  = 0;
			next_point = 1;
			errors     = 0;
		endfunction

		static function int s24(logic [COORD_W-1:0] v);
			return int'($signed(v));
		endfunction

		// strict containment, exact integer math
		function bit contains(entry_t f, int px, int py);
			longint dx, dy, r;
			if (f.kind == KIND_RECT) begin
				return px > s24(f.left_or_cx) && px < s24(f.right_or_radius) &&
					py < s24(f.top_or_cy) && py > s24(f.bottom);
			end
			dx = longint'(px) - longint'(s24(f.left_or_cx));
			dy = longint'(py) - longint'(s24(f.top_or_cy));
			r  = longint'(f.right_or_radius[RADIUS_W-1:0]);
			return dx * dx + dy * dy < r * r;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		// accepted item beat: update table, queue the owed result beats
		function void take_item(in_beat_t b);
			int unsigned hit_idx[$];
			out_beat_t   want;
			int          px, py;
			case (b.operation)
			OP_CLEAR: begin
				fig_count  = 0;
				next_point = 1;
			end
			OP_ADD: begin
				if (fig_count < TABLE_DEPTH) begin
					figures[fig_count].kind       = b.figure_kind;
					figures[fig_count].left_or_cx = b.first_x;
					figures[fig_count].top_or_cy  = b.first_y;
					if (b.figure_kind == KIND_RECT) begin
						figures[fig_count].right_or_radius = b.second_x;
						figures[fig_count].bottom          = b.second_y;
					end else begin
						figures[fig_count].right_or_radius = {1'b0, b.radius};
						figures[fig_count].bottom          = '0;
					end
					fig_count++;
				end
			end
			OP_TEST: begin
				px = s24(b.point_x);
				py = s24(b.point_y);
				for (int unsigned i = 0; i < fig_count; i++)
					if (contains(figures[i], px, py))
						hit_idx.push_back(i + 1);
				want.point_number = next_point;
				if (hit_idx.size() == 0) begin
					want.figure_number = '0;
					want.contained     = 1'b0;
					want.last_result   = 1'b1;
					owed_hits.push_back(want);
				end else begin
					foreach (hit_idx[j]) begin
						want.figure_number = FIG_W'(hit_idx[j]);
						want.contained     = 1'b1;
						want.last_result   = (j == hit_idx.size() - 1);
						owed_hits.push_back(want);
					end
				end
				next_point = (next_point == '1) ? PNUM_W'(1) : next_point + 1'b1;
			end
			default: ;
			endcase
		endfunction

		task check_result(out_beat_t got);
			out_beat_t want;
			if (owed_hits.size() == 0) begin
				report($sformatf("result beat with nothing owed: pnum=%0d fig=%0d",
					got.point_number, got.figure_number));
				return;
			end
			want = owed_hits.pop_front();
			if (got.point_number !== want.point_number)
				report($sformatf("point_number got %0d want %0d",
					got.point_number, want.point_number));
			if (got.figure_number !== want.figure_number)
				report($sformatf("pnum %0d figure_number got %0d want %0d",
					want.point_number, got.figure_number, want.figure_number));
			if (got.contained !== want.contained)
				report($sformatf("pnum %0d fig %0d contained got %b want %b",
					want.point_number, want.figure_number, got.contained,
					want.contained));
			if (got.last_result !== want.last_result)
				report($sformatf("pnum %0d fig %0d last_result got %b want %b",
					want.point_number, want.figure_number, got.last_result,
					want.last_result));
		endtask
	endclass

endpackage

module point_in_rect_circle_hit_test_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import prch_pkg::*;
	import hit_test_tb_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 3;
	// slowest legal gap between two handshakes (send gap, full 16-figure scan,
	// result stall); take it many times over
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RANDOM_ITEMS   = 396;
	localparam int COORD_MAX      = 8388607;
	localparam int COORD_MIN      = -8388608;
	localparam int IN_W           = $bits(in_beat_t);

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_beat_t  item;
	logic      result_valid;
	logic      result_ready;
	out_beat_t result;

	hit_list_checker hits;

	int items_sent;
	int idle_cycles;

	// centres and half-sizes of recent figures, used to aim probe points
	int anchor_x[$];
	int anchor_y[$];
	int anchor_w[$];
	int anchor_h[$];

	point_in_rect_circle_hit_test_unit #(
		.MAX_FIGURES(TABLE_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Field helpers. Fields the operation does not read are left random so
	// that every input bit toggles.
	// ------------------------------------------------------------------
	function automatic in_beat_t rand_beat(logic [1:0] op);
		in_beat_t b;
		b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		b.operation = op;
		return b;
	endfunction

	function automatic int rand24();
		logic signed [COORD_W-1:0] v;
		v = COORD_W'($urandom);
		return v;
	endfunction

	function automatic int clamp24(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return int'(v);
	endfunction

	// uniform offset in [-w-1, w+1], so edges and one step past them show up
	function automatic int spread(int w);
		return int'($urandom_range(0, 2 * w + 2)) - w - 1;
	endfunction

	function automatic in_beat_t make_rect(int l, int t, int r, int bot);
		in_beat_t b;
		b             = rand_beat(OP_ADD);
		b.figure_kind = KIND_RECT;
		b.first_x     = COORD_W'(l);
		b.first_y     = COORD_W'(t);
		b.second_x    = COORD_W'(r);
		b.second_y    = COORD_W'(bot);
		return b;
	endfunction

	function automatic in_beat_t make_circle(int cx, int cy, int r);
		in_beat_t b;
		b             = rand_beat(OP_ADD);
		b.figure_kind = KIND_CIRCLE;
		b.first_x     = COORD_W'(cx);
		b.first_y     = COORD_W'(cy);
		b.radius      = RADIUS_W'(r);
		return b;
	endfunction

	function automatic in_beat_t make_test(int px, int py);
		in_beat_t b;
		b         = rand_beat(OP_TEST);
		b.point_x = COORD_W'(px);
		b.point_y = COORD_W'(py);
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Item driver. Valid stays up back to back when no gap is drawn, so it
	// is never dropped and raised in the same step.
	// ------------------------------------------------------------------
	task automatic send_item(in_beat_t b);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= b;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && item_ready));
		if (b.operation != OP_UNUSED)
			items_sent++;
	endtask

	task automatic clear_table();
		send_item(rand_beat(OP_CLEAR));
		anchor_x.delete();
		anchor_y.delete();
		anchor_w.delete();
		anchor_h.delete();
	endtask

	// random figure; narrow scenes pack small figures around the origin so
	// that they overlap and share edges, wide ones span the whole range
	task automatic add_random_figure(bit wide);
		int cx, cy, span, w, h, tmp;
		int l, t, r, bot;
		if (wide) begin
			cx   = rand24();
			cy   = rand24();
			span = $urandom_range(0, 4194304);
		end else begin
			cx   = int'($urandom_range(0, 512)) - 256;
			cy   = int'($urandom_range(0, 512)) - 256;
			span = $urandom_range(0, 64);
		end
		if ($urandom_range(0, 1) == 0) begin
			w   = $urandom_range(0, span);
			h   = $urandom_range(0, span);
			l   = clamp24(longint'(cx) - w);
			r   = clamp24(longint'(cx) + w);
			t   = clamp24(longint'(cy) + h);
			bot = clamp24(longint'(cy) - h);
			// now and then an inverted rectangle, which must never hit
			case ($urandom_range(0, 7))
			0: begin
				tmp = l;
				l   = r;
				r   = tmp;
			end
			1: begin
				tmp = t;
				t   = bot;
				bot = tmp;
			end
			default: ;
			endcase
			send_item(make_rect(l, t, r, bot));
		end else begin
			w = span;
			h = span;
			send_item(make_circle(cx, cy, span));
		end
		anchor_x.push_back(cx);
		anchor_y.push_back(cy);
		anchor_w.push_back(w);
		anchor_h.push_back(h);
		if (anchor_x.size() > 24) begin
			void'(anchor_x.pop_front());
			void'(anchor_y.pop_front());
			void'(anchor_w.pop_front());
			void'(anchor_h.pop_front());
		end
	endtask

	// probe point: mostly near a known figure, often right on its boundary
	task automatic aim_test();
		int k, px, py;
		px = rand24();
		py = rand24();
		if (anchor_x.size() != 0 && $urandom_range(0, 4) != 0) begin
			k = $urandom_range(0, anchor_x.size() - 1);
			case ($urandom_range(0, 3))
			0: begin
				// on the left/right edge (or the circle's rim on the x axis)
				px = clamp24(longint'(anchor_x[k]) +
					($urandom_range(0, 1) ? anchor_w[k] : -anchor_w[k]));
				py = anchor_y[k];
			end
			1: begin
				px = anchor_x[k];
				py = clamp24(longint'(anchor_y[k]) +
					($urandom_range(0, 1) ? anchor_h[k] : -anchor_h[k]));
			end
			default: begin
				px = clamp24(longint'(anchor_x[k]) + spread(anchor_w[k]));
				py = clamp24(longint'(anchor_y[k]) + spread(anchor_h[k]));
			end
			endcase
		end
		send_item(make_test(px, py));
	endtask

	// one scene: maybe clear, load a few figures (sometimes past capacity),
	// probe a few points, and sprinkle in a raw random item
	task automatic run_scene();
		bit wide;
		int n_add, n_test;
		wide = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 2) != 0)
			clear_table();
		n_add  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
		n_test = $urandom_range(1, 6);
		repeat (n_add)
			add_random_figure(wide);
		repeat (n_test) begin
			aim_test();
			if ($urandom_range(0, 11) == 0)
				send_item(rand_beat(2'($urandom_range(0, 3))));
		end
	endtask

	// ------------------------------------------------------------------
	// Monitors: sample at the clock edge, before the edge's updates land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			hits.take_item(item);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			hits.check_result(result);
	end

	// Result sink: before each beat, hold ready low for a drawn number of
	// cycles, then keep it high until the beat is taken.
	initial begin
		int stall;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 11);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	// Watchdog: too long without any beat on either channel means a hang.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int target;
		hits        = new();
		items_sent  = 0;
		arst_n      <= 1'b0;
		item_valid  <= 1'b0;
		item        <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening.
		// Test on the empty table right after reset: one not-contained beat.
		send_item(make_test(0, 0));
		// Unused opcode, then a clear of an already empty table.
		send_item(rand_beat(OP_UNUSED));
		clear_table();
		// Figure 1: the largest rectangle. Figure 2: largest circle at origin.
		send_item(make_rect(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_item(make_circle(0, 0, COORD_MAX));
		// Figures 3, 4: inverted rectangles (zero width; bottom above top).
		send_item(make_rect(100, 50, 100, -50));
		send_item(make_rect(-100, -50, 100, 50));
		// Figure 5: zero radius circle, contains nothing.
		send_item(make_circle(0, 0, 0));
		send_item(make_test(0, 0));
		// On the left edge of figure 1 and outside the circle.
		send_item(make_test(COORD_MIN, 0));
		// On the right edge of figure 1 and exactly on the circle's rim.
		send_item(make_test(COORD_MAX, 0));
		// Inside figure 1 only.
		send_item(make_test(-COORD_MAX, COORD_MAX - 1));
		// Fill the table to capacity with figures around the origin.
		for (int k = 0; k < 11; k++) begin
			if (k % 2 == 0)
				send_item(make_rect(-(k + 1) * 256, (k + 1) * 256, (k + 1) * 256,
					-(k + 1) * 256));
			else
				send_item(make_circle(k * 16, -k * 16, 4096));
		end
		// Table full: this one is dropped.
		send_item(make_circle(1, -1, 8000));
		// Hits every figure but the three empty ones, up to figure 16.
		send_item(make_test(1, -1));

		// Random scenes.
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target)
			run_scene();

		item_valid <= 1'b0;
		// let the monitor log the final beat before looking at what is owed
		@(posedge clk);
		while (hits.owed_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (hits.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> point_in_rect_circle_hit_test_unit.f
rtl/prch_pkg.sv
rtl/prch_ctrl.sv
rtl/prch_dp.sv
rtl/point_in_rect_circle_hit_test_unit.sv
verif/point_in_rect_circle_hit_test_unit_tb.sv
